### sv/hsvsa_pkg.sv
// Shared types and constants of the HSV saturation adjust block.
// Used by hsvsa_div and hsv_saturation_adjust_core; depends on nothing else.
package hsvsa_pkg;

  // Pipelined divider: numerator, denominator and quotient widths.
  localparam int unsigned DIV_NW = 17;
  localparam int unsigned DIV_DW = 9;
  localparam int unsigned DIV_QW = 8;

  // Reciprocal division for the back conversion: q = (n * RECIP) >> RECIP_K.
  localparam int unsigned RECIP_K   = 22;
  localparam int unsigned RECIP_510 = 8224;
  localparam int unsigned RECIP_15K = 274;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL   = 3'd0,
    SEC_YEL_GRN   = 3'd1,
    SEC_GRN_CYAN  = 3'd2,
    SEC_CYAN_BLUE = 3'd3,
    SEC_BLUE_MAG  = 3'd4,
    SEC_MAG_RED   = 3'd5
  } sector_e;

endpackage

### sv/hsvsa_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on hsvsa_pkg for its widths; the quotient must fit in DIV_QW bits.
module hsvsa_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [hsvsa_pkg::DIV_NW-1:0]   num_i,
  input  logic [hsvsa_pkg::DIV_DW-1:0]   den_i,
  output logic [hsvsa_pkg::DIV_QW-1:0]   quo_o
);

  localparam int unsigned QW = hsvsa_pkg::DIV_QW;
  localparam int unsigned DW = hsvsa_pkg::DIV_DW;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      // The upper numerator bits are already below the divisor.
      assign rem_in = num_i[hsvsa_pkg::DIV_NW-1:QW];
      assign lo_in  = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, lo_in[QW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        lo_q[k]  <= {lo_in[QW-2:0], 1'b0};
        quo_q[k] <= {quo_in[QW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

### sv/hsv_saturation_adjust_core.sv
// HSV saturation adjust: converts each RGB pixel to HSV, scales S, converts back.
// Depends on hsvsa_pkg and hsvsa_div.
//
// Usage:
//   Pixels enter on the s_axis request channel (tdata = red, green, blue from
//   the low byte up) and leave on the m_axis channel in the same packing, one
//   result per pixel, in order.
//   The saturation gain (unsigned Q2.GAIN_FRAC_BITS) is written on the cfg
//   channel, which is always ready; write it only while no pixel is in flight.
//   A gain of exactly 1.0 returns every pixel unchanged.
// Timing:
//   One pixel is accepted every cycle while the output is not stalled; the
//   depth is set by the two 8-stage pipelined dividers (saturation and hue)
//   plus the multiply and rounding stages.
// Reset:
//   rst_ni clears all stage valid bits and sets the gain to 1.0.
// Stall:
//   When m_axis_tready is low with a valid result, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
module hsv_saturation_adjust_core #(
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // red_in, green_in, blue_in
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // red_out, green_out, blue_out
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [GAIN_FRAC_BITS+1:0]   cfg_data_i
);

  localparam int unsigned GW    = GAIN_FRAC_BITS + 2;
  localparam int unsigned SPW   = 8 + GW;
  localparam int unsigned BW    = GW + 10;
  localparam int unsigned ONE   = 1 << GAIN_FRAC_BITS;
  localparam int unsigned HALF  = 1 << (GAIN_FRAC_BITS - 1);
  localparam int unsigned NST   = 14;
  localparam int unsigned DST   = hsvsa_pkg::DIV_QW;  // stage of divider outputs
  localparam int unsigned ST_P1 = DST + 2;
  localparam int unsigned ST_R1 = DST + 4;
  localparam int unsigned NW    = hsvsa_pkg::DIV_NW;
  localparam int unsigned DW    = hsvsa_pkg::DIV_DW;

  // Gain register and bypass decision.
  logic [GW-1:0] gain_q;
  logic [GW-1:0] dev;
  logic [BW-1:0] dev_x;
  logic          bypass;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GW'(ONE);
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  assign dev    = (gain_q > GW'(ONE)) ? gain_q - GW'(ONE) : GW'(ONE) - gain_q;
  assign dev_x  = BW'(dev) * BW'(1000);
  assign bypass = (dev_x < BW'(ONE));

  // Global stall: everything advances unless a result is held.
  logic           en;
  logic [NST-1:0] vld_q;

  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Pixel and value travel alongside the data stages.
  hsvsa_pkg::rgb_t pix_in;
  hsvsa_pkg::rgb_t pix_q [NST-1];
  logic [7:0]      v_q   [NST-1];
  logic            mxz_q [DST+1];
  logic            dfz_q [DST+1];

  assign pix_in = hsvsa_pkg::rgb_t'(s_axis_tdata);

  // Stage 0: max, min and divider operands.
  logic [7:0]          mx, mn, diff;
  logic signed [11:0]  hnum_raw;
  logic [10:0]         hnum;
  logic [NW-1:0]       ns_q, nh_q;
  logic [DW-1:0]       ds_q, dh_q;

  always_comb begin
    mx = pix_in.red;
    mn = pix_in.red;
    if (pix_in.green > mx) mx = pix_in.green;
    if (pix_in.blue > mx)  mx = pix_in.blue;
    if (pix_in.green < mn) mn = pix_in.green;
    if (pix_in.blue < mn)  mn = pix_in.blue;
    diff = mx - mn;
    priority if (mx == pix_in.red) begin
      hnum_raw = 12'(signed'({1'b0, pix_in.green})) - 12'(signed'({1'b0, pix_in.blue}));
    end else if (mx == pix_in.green) begin
      hnum_raw = 12'(signed'({1'b0, pix_in.blue})) - 12'(signed'({1'b0, pix_in.red}))
               + 12'(signed'({2'b0, diff, 1'b0}));
    end else begin
      hnum_raw = 12'(signed'({1'b0, pix_in.red})) - 12'(signed'({1'b0, pix_in.green}))
               + 12'(signed'({2'b0, diff, 2'b0}));
    end
    if (hnum_raw < 0) begin
      hnum = 11'(hnum_raw + 12'(signed'({1'b0, 11'(diff) * 11'd6})));
    end else begin
      hnum = hnum_raw[10:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ns_q     <= NW'(diff) * NW'(510) + NW'(mx);
      ds_q     <= {mx, 1'b0};
      nh_q     <= NW'(hnum) * NW'(60) + NW'(diff);
      dh_q     <= {diff, 1'b0};
      pix_q[0] <= pix_in;
      v_q[0]   <= mx;
      mxz_q[0] <= (mx == 8'd0);
      dfz_q[0] <= (diff == 8'd0);
    end
  end

  for (genvar k = 1; k < NST - 1; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        pix_q[k] <= pix_q[k-1];
        v_q[k]   <= v_q[k-1];
      end
    end
  end

  for (genvar k = 1; k <= DST; k++) begin : g_flag
    always_ff @(posedge clk_i) begin
      if (en) begin
        mxz_q[k] <= mxz_q[k-1];
        dfz_q[k] <= dfz_q[k-1];
      end
    end
  end

  // Stages 1 to 8: saturation and hue divisions.
  logic [7:0] qs, qh;

  hsvsa_div u_div_sat (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ns_q),
    .den_i (ds_q),
    .quo_o (qs)
  );

  hsvsa_div u_div_hue (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nh_q),
    .den_i (dh_q),
    .quo_o (qh)
  );

  // Stage M: gain, hue fold, sector.
  logic [7:0]          s_val, h_raw, h_fold, s2;
  logic [SPW-1:0]      s_prod, s_rnd;
  logic [SPW-GAIN_FRAC_BITS-1:0] s_scl;
  hsvsa_pkg::sector_e  sec;
  logic [4:0]          f_val;
  logic [7:0]          s2_q;
  hsvsa_pkg::sector_e  sec_q [4];
  logic [4:0]          f_q;

  always_comb begin
    s_val  = mxz_q[DST] ? 8'd0 : qs;
    h_raw  = dfz_q[DST] ? 8'd0 : qh;
    h_fold = (h_raw >= 8'd180) ? h_raw - 8'd180 : h_raw;
    s_prod = SPW'(s_val) * SPW'(gain_q);
    s_rnd  = s_prod + SPW'(HALF);
    s_scl  = s_rnd[SPW-1:GAIN_FRAC_BITS];
    s2     = (|s_scl[SPW-GAIN_FRAC_BITS-1:8]) ? 8'hFF : s_scl[7:0];
    priority if (h_fold >= 8'd150) begin
      sec = hsvsa_pkg::SEC_MAG_RED;   f_val = 5'(h_fold - 8'd150);
    end else if (h_fold >= 8'd120) begin
      sec = hsvsa_pkg::SEC_BLUE_MAG;  f_val = 5'(h_fold - 8'd120);
    end else if (h_fold >= 8'd90) begin
      sec = hsvsa_pkg::SEC_CYAN_BLUE; f_val = 5'(h_fold - 8'd90);
    end else if (h_fold >= 8'd60) begin
      sec = hsvsa_pkg::SEC_GRN_CYAN;  f_val = 5'(h_fold - 8'd60);
    end else if (h_fold >= 8'd30) begin
      sec = hsvsa_pkg::SEC_YEL_GRN;   f_val = 5'(h_fold - 8'd30);
    end else begin
      sec = hsvsa_pkg::SEC_RED_YEL;   f_val = h_fold[4:0];
    end
  end

  // Stage P1: saturation times hue fraction.
  logic [12:0] a_q, b_q;
  logic [7:0]  pc_q;
  logic        grey_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q      <= s2;
      sec_q[0]  <= sec;
      f_q       <= f_val;
      grey_q[0] <= (s2 == 8'd0);
      a_q       <= 13'd7650 - 13'(s2_q) * 13'(f_q);
      b_q       <= 13'd7650 - 13'(s2_q) * 13'(5'd30 - f_q);
      pc_q      <= 8'd255 - s2_q;
      sec_q[1]  <= sec_q[0];
      grey_q[1] <= grey_q[0];
    end
  end

  // Stage P2: scale by value and form rounding numerators.
  logic [16:0] np_q;
  logic [21:0] nq_q, nt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      np_q      <= {16'(v_q[ST_P1]) * 16'(pc_q), 1'b0} + 17'd255;
      nq_q      <= {21'(v_q[ST_P1]) * 21'(a_q), 1'b0} + 22'd7650;
      nt_q      <= {21'(v_q[ST_P1]) * 21'(b_q), 1'b0} + 22'd7650;
      sec_q[2]  <= sec_q[1];
      grey_q[2] <= grey_q[1];
    end
  end

  // Stage R1: reciprocal estimates, at most one below the true quotient.
  logic [30:0] pp, pq, pt;
  logic [8:0]  ep_q, eq_q, et_q;
  logic [16:0] np2_q;
  logic [21:0] nq2_q, nt2_q;

  assign pp = 31'(np_q) * 31'(hsvsa_pkg::RECIP_510);
  assign pq = 31'(nq_q) * 31'(hsvsa_pkg::RECIP_15K);
  assign pt = 31'(nt_q) * 31'(hsvsa_pkg::RECIP_15K);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ep_q      <= pp[30:hsvsa_pkg::RECIP_K];
      eq_q      <= pq[30:hsvsa_pkg::RECIP_K];
      et_q      <= pt[30:hsvsa_pkg::RECIP_K];
      np2_q     <= np_q;
      nq2_q     <= nq_q;
      nt2_q     <= nt_q;
      sec_q[3]  <= sec_q[2];
      grey_q[3] <= grey_q[2];
    end
  end

  // Stage R2: correct estimates, pick channels, output register.
  logic [16:0] rp;
  logic [21:0] rq, rt;
  logic [7:0]  p_v, q_v, t_v, v_v;
  hsvsa_pkg::rgb_t res, out_q;

  always_comb begin
    rp  = np2_q - 17'(ep_q) * 17'd510;
    rq  = nq2_q - 22'(eq_q) * 22'd15300;
    rt  = nt2_q - 22'(et_q) * 22'd15300;
    p_v = 8'(ep_q) + 8'(rp >= 17'd510);
    q_v = 8'(eq_q) + 8'(rq >= 22'd15300);
    t_v = 8'(et_q) + 8'(rt >= 22'd15300);
    v_v = v_q[ST_R1];
    unique case (sec_q[3])
      hsvsa_pkg::SEC_RED_YEL:   res = '{red: v_v, green: t_v, blue: p_v};
      hsvsa_pkg::SEC_YEL_GRN:   res = '{red: q_v, green: v_v, blue: p_v};
      hsvsa_pkg::SEC_GRN_CYAN:  res = '{red: p_v, green: v_v, blue: t_v};
      hsvsa_pkg::SEC_CYAN_BLUE: res = '{red: p_v, green: q_v, blue: v_v};
      hsvsa_pkg::SEC_BLUE_MAG:  res = '{red: t_v, green: p_v, blue: v_v};
      default:                  res = '{red: v_v, green: p_v, blue: q_v};
    endcase
    if (grey_q[3]) begin
      res = '{red: v_v, green: v_v, blue: v_v};
    end
    if (bypass) begin
      res = pix_q[ST_R1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = out_q;

endmodule
